// ----- src/hstl_pkg.sv -----
// Shared types and constants of the hashed symbol table core.
package hstl_pkg;

    localparam int NAME_CHARS = 6;
    localparam int CHAR_BITS  = 8;
    localparam int NAME_W     = NAME_CHARS * CHAR_BITS;
    localparam logic [CHAR_BITS-1:0] CHAR_MASK = 8'h7f;

    localparam int HASH_W       = 16;
    localparam int PAIRS        = (NAME_CHARS + 1) / 2;
    localparam int RECIP_SHIFT  = 32;
    localparam int REDUCE_STEPS = 2;
    localparam int REDUCE_CNT_W = (REDUCE_STEPS > 1) ? $clog2(REDUCE_STEPS) : 1;

    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        F_IDLE,
        F_REDUCE
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE
    } back_state_t;

endpackage

// ----- src/hstl_if.sv -----
// Request and response stream interfaces of the hashed symbol table core.
interface hstl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [hstl_pkg::NAME_W-1:0] symbol_name;

    modport source (output valid, output operation, output symbol_name, input ready);
    modport sink   (input valid, input operation, input symbol_name, output ready);
endinterface

interface hstl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hstl_pkg::STATUS_W-1:0] status;
    logic [hstl_pkg::INDEX_W-1:0]  entry_index;

    modport source (output valid, output status, output entry_index, input ready);
    modport sink   (input valid, input status, input entry_index, output ready);
endinterface

// ----- src/hstl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hstl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/hstl_fifo.sv -----
// Two-entry queue between the hashing front and the probing back.
module hstl_fifo #(
    parameter int WIDTH = 57
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

// ----- src/hstl_front.sv -----
// Request front: accept an item, hash its name and reduce the hash to a home slot.
module hstl_front #(
    parameter int SLOTS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    hstl_req_if.sink                    req,
    input  logic                        clearing,
    input  logic                        fifo_full,
    output logic                        push,
    output logic                        push_op,
    output logic [hstl_pkg::NAME_W-1:0] push_name,
    output logic [$clog2(SLOTS)-1:0]    push_home
);

    localparam int IDXW   = $clog2(SLOTS);
    localparam int PAD_W  = hstl_pkg::PAIRS * 16;
    localparam int PROD_W = hstl_pkg::HASH_W + hstl_pkg::RECIP_SHIFT;
    localparam longint unsigned RECIP_L =
        ((64'd1 << hstl_pkg::RECIP_SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [hstl_pkg::RECIP_SHIFT-1:0] RECIP = hstl_pkg::RECIP_SHIFT'(RECIP_L);
    localparam logic [hstl_pkg::HASH_W-1:0] SLOTS_H = hstl_pkg::HASH_W'(SLOTS);
    localparam logic [hstl_pkg::REDUCE_CNT_W-1:0] LAST_CNT =
        hstl_pkg::REDUCE_CNT_W'(hstl_pkg::REDUCE_STEPS - 1);

    hstl_pkg::front_state_t state_reg;
    hstl_pkg::front_state_t state_next;

    logic                              op_reg;
    logic [hstl_pkg::NAME_W-1:0]       name_reg;
    logic [hstl_pkg::HASH_W-1:0]       dvd_reg;
    logic [hstl_pkg::HASH_W-1:0]       quot_reg;
    logic [PROD_W-1:0]                 prod;
    logic [hstl_pkg::HASH_W-1:0]       quot_slots;
    logic [hstl_pkg::HASH_W-1:0]       rem;
    logic [hstl_pkg::REDUCE_CNT_W-1:0] cnt_reg;
    logic [hstl_pkg::HASH_W-1:0]       sum;
    logic                              accept;
    logic                              last;

    assign accept = req.valid && req.ready;
    assign last   = (cnt_reg == LAST_CNT);

    // Sum big-endian character pairs, pad an odd last character with zero.
    always_comb
    begin
        logic [PAD_W-1:0] padded;
        padded = PAD_W'(req.symbol_name) << (PAD_W - hstl_pkg::NAME_W);
        sum = '0;
        for (int k = 0; k < hstl_pkg::PAIRS; k++)
        begin
            sum = sum + padded[PAD_W-1-16*k -: 16];
        end
    end

    // Quotient by reciprocal multiplication, then remainder by multiply and subtract.
    assign prod       = PROD_W'(dvd_reg) * PROD_W'(RECIP);
    assign quot_slots = quot_reg * SLOTS_H;
    assign rem        = dvd_reg - quot_slots;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hstl_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = hstl_pkg::F_REDUCE;
                end
            end
            hstl_pkg::F_REDUCE:
            begin
                if (last)
                begin
                    state_next = hstl_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = hstl_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        push      = 1'b0;
        unique case (state_reg)
            hstl_pkg::F_IDLE:
            begin
                req.ready = !clearing && !fifo_full;
            end
            hstl_pkg::F_REDUCE:
            begin
                push = last;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign push_op   = op_reg;
    assign push_name = name_reg;
    assign push_home = rem[IDXW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.operation;
            name_reg <= req.symbol_name;
            dvd_reg  <= sum;
        end
        quot_reg <= prod[PROD_W-1 -: hstl_pkg::HASH_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hstl_pkg::F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == hstl_pkg::F_REDUCE)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

endmodule

// ----- src/hstl_back.sv -----
// Probing back: clear the table, walk slots from home, insert and report.
module hstl_back #(
    parameter int SLOTS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fifo_empty,
    input  logic                        head_op,
    input  logic [hstl_pkg::NAME_W-1:0] head_name,
    input  logic [$clog2(SLOTS)-1:0]    head_home,
    output logic                        pop,
    output logic                        clearing,
    hstl_rsp_if.source                  rsp
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int CW   = hstl_pkg::CHAR_BITS;
    localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(SLOTS - 1);

    hstl_pkg::back_state_t state_reg;
    hstl_pkg::back_state_t state_next;

    logic                        op_reg;
    logic [hstl_pkg::NAME_W-1:0] name_reg;
    logic [IDXW-1:0]             home_reg;
    logic [IDXW-1:0]             slot_reg;
    logic [IDXW-1:0]             slot_wrap;
    logic [IDXW-1:0]             cnt_reg;

    logic                        out_valid_reg;
    hstl_pkg::status_t           out_status_reg;
    logic [hstl_pkg::INDEX_W-1:0] out_index_reg;

    logic                        we;
    logic [IDXW-1:0]             waddr;
    logic [hstl_pkg::NAME_W-1:0] wdata;
    logic [IDXW-1:0]             raddr;
    logic [hstl_pkg::NAME_W-1:0] rdata;

    logic                        hit_empty;
    logic                        hit_match;
    logic                        exhausted;
    logic                        done;
    logic                        start;
    hstl_pkg::status_t           result_status;
    logic [IDXW-1:0]             result_slot;
    logic [IDXW+7:0]             result_ext;

    hstl_ram #(
        .WIDTH (hstl_pkg::NAME_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign slot_wrap = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign hit_empty = (rdata[hstl_pkg::NAME_W-1 -: CW] & hstl_pkg::CHAR_MASK) == '0;
    assign exhausted = (cnt_reg == LAST_SLOT);
    assign done      = hit_empty || hit_match || exhausted;
    assign start     = !fifo_empty && !out_valid_reg;

    always_comb
    begin
        hit_match = 1'b1;
        for (int k = 0; k < hstl_pkg::NAME_CHARS; k++)
        begin
            if ((rdata[k*CW +: CW] & hstl_pkg::CHAR_MASK) !=
                (name_reg[k*CW +: CW] & hstl_pkg::CHAR_MASK))
            begin
                hit_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        priority if (hit_empty)
        begin
            result_status = op_reg ? hstl_pkg::ST_INSERTED : hstl_pkg::ST_ABSENT;
            result_slot   = slot_reg;
        end
        else if (hit_match)
        begin
            result_status = hstl_pkg::ST_FOUND;
            result_slot   = slot_reg;
        end
        else
        begin
            result_status = hstl_pkg::ST_FULL;
            result_slot   = home_reg;
        end
    end

    assign result_ext = {8'b0, result_slot};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hstl_pkg::B_CLEAR:
            begin
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = hstl_pkg::B_IDLE;
                end
            end
            hstl_pkg::B_IDLE:
            begin
                if (start)
                begin
                    state_next = hstl_pkg::B_PROBE;
                end
            end
            hstl_pkg::B_PROBE:
            begin
                if (done)
                begin
                    state_next = hstl_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = hstl_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        we       = 1'b0;
        waddr    = slot_reg;
        wdata    = name_reg;
        raddr    = slot_wrap;
        pop      = 1'b0;
        clearing = 1'b0;
        unique case (state_reg)
            hstl_pkg::B_CLEAR:
            begin
                we       = 1'b1;
                wdata    = '0;
                clearing = 1'b1;
            end
            hstl_pkg::B_IDLE:
            begin
                pop   = start;
                raddr = head_home;
            end
            hstl_pkg::B_PROBE:
            begin
                we = hit_empty && op_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_index = out_index_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg   <= head_op;
            name_reg <= head_name;
            home_reg <= head_home;
        end
        if ((state_reg == hstl_pkg::B_PROBE) && done)
        begin
            out_status_reg <= result_status;
            out_index_reg  <= result_ext[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hstl_pkg::B_CLEAR;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                hstl_pkg::B_CLEAR:
                begin
                    slot_reg <= slot_wrap;
                end
                hstl_pkg::B_IDLE:
                begin
                    slot_reg <= head_home;
                    cnt_reg  <= '0;
                end
                hstl_pkg::B_PROBE:
                begin
                    slot_reg <= slot_wrap;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                default:
                begin
                    slot_reg <= slot_reg;
                end
            endcase
            if ((state_reg == hstl_pkg::B_PROBE) && done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- src/hashed_symbol_table_lookup_insert_core.sv -----
// Top level of the hashed symbol table lookup and insert core.
// A request is hashed and reduced to its home slot in the front by these steps
// (accept, a reciprocal multiply for the quotient, then the remainder by SLOTS),
// and the front takes a new item only once it has pushed the last one to the
// queue. The back starts an item from its idle state and probes one slot per
// cycle, set by the single read port of the name table, and starts the next
// item only once the previous response has been taken. A long probe chain, up
// to SLOTS probes on a full table, holds the back and stalls the front once the
// two-entry queue is full. After reset the back sweeps all SLOTS entries of the
// table to empty, and no item is accepted during that sweep. Each item gives
// exactly one response, held in an output register until taken.
module hashed_symbol_table_lookup_insert_core #(
    parameter int SLOTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    hstl_req_if.sink    req,
    hstl_rsp_if.source  rsp
);

    localparam int IDXW    = $clog2(SLOTS);
    localparam int ENTRY_W = 1 + hstl_pkg::NAME_W + IDXW;

    logic                        clearing;
    logic                        fifo_full;
    logic                        fifo_empty;
    logic                        push;
    logic                        pop;
    logic                        push_op;
    logic [hstl_pkg::NAME_W-1:0] push_name;
    logic [IDXW-1:0]             push_home;
    logic [ENTRY_W-1:0]          head;

    hstl_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .clearing  (clearing),
        .fifo_full (fifo_full),
        .push      (push),
        .push_op   (push_op),
        .push_name (push_name),
        .push_home (push_home)
    );

    hstl_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_op, push_name, push_home}),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (fifo_empty)
    );

    hstl_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .head_op    (head[ENTRY_W-1]),
        .head_name  (head[ENTRY_W-2 -: hstl_pkg::NAME_W]),
        .head_home  (head[IDXW-1:0]),
        .pop        (pop),
        .clearing   (clearing),
        .rsp        (rsp)
    );

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready)
        else $error("item accepted during table clear");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("queue overflow");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!fifo_empty && !rsp.valid))
        else $error("queue underflow or result overwritten");

    a_result_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !$past(rsp.valid)) |-> !clearing)
        else $error("result raised during table clear");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench of the hashed symbol table lookup and insert core.
module tb;

    localparam int SLOTS      = 256;
    localparam int NAME_CHARS = hstl_pkg::NAME_CHARS;
    localparam int NAME_W     = hstl_pkg::NAME_W;
    localparam int CHAR_BITS  = hstl_pkg::CHAR_BITS;
    localparam int HASH_W     = hstl_pkg::HASH_W;
    localparam int INDEX_W    = hstl_pkg::INDEX_W;
    localparam int STATUS_W   = hstl_pkg::STATUS_W;
    localparam logic [CHAR_BITS-1:0] CHAR_MASK = hstl_pkg::CHAR_MASK;
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 250;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 100;
    localparam int DRAIN_CYCLES = 300;

    class symbol_table_scoreboard;
        typedef struct packed {
            hstl_pkg::status_t   status;
            logic [INDEX_W-1:0]  entry_index;
        } outcome_t;

        logic [NAME_W-1:0] names [SLOTS];
        outcome_t          awaited [$];
        int unsigned       filled;
        int unsigned       errors;
        int unsigned       seen [4];

        function new();
            foreach (names[i]) names[i] = '0;
            filled = 0;
            errors = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function int unsigned home_of(logic [NAME_W-1:0] nm);
            logic [HASH_W-1:0] sum;
            logic [CHAR_BITS-1:0] hi;
            logic [CHAR_BITS-1:0] lo;
            sum = '0;
            for (int k = 0; k < NAME_CHARS; k += 2)
            begin
                hi = nm[NAME_W-1-k*CHAR_BITS -: CHAR_BITS];
                lo = (k + 1 < NAME_CHARS) ? nm[NAME_W-1-(k+1)*CHAR_BITS -: CHAR_BITS] : '0;
                sum = sum + {hi, lo};
            end
            return sum % SLOTS;
        endfunction

        function bit is_vacant(logic [NAME_W-1:0] nm);
            return (nm[NAME_W-1 -: CHAR_BITS] & CHAR_MASK) == '0;
        endfunction

        function bit same_name(logic [NAME_W-1:0] a, logic [NAME_W-1:0] b);
            logic [NAME_W-1:0] m;
            m = {NAME_CHARS{CHAR_MASK}};
            return (a & m) == (b & m);
        endfunction

        function void note_request(logic op, logic [NAME_W-1:0] nm);
            int unsigned home;
            int unsigned slot;
            hstl_pkg::status_t st;
            outcome_t o;
            home = home_of(nm);
            slot = home;
            st = hstl_pkg::ST_FULL;
            for (int n = 0; n < SLOTS; n++)
            begin
                if (is_vacant(names[slot]))
                begin
                    if (op == OP_INSERT)
                    begin
                        names[slot] = nm;
                        st = hstl_pkg::ST_INSERTED;
                        if (!is_vacant(nm)) filled++;
                    end
                    else
                    begin
                        st = hstl_pkg::ST_ABSENT;
                    end
                    break;
                end
                if (same_name(nm, names[slot]))
                begin
                    st = hstl_pkg::ST_FOUND;
                    break;
                end
                slot = (slot + 1 == SLOTS) ? 0 : slot + 1;
            end
            if (st == hstl_pkg::ST_FULL) slot = home;
            o.status = st;
            o.entry_index = INDEX_W'(slot);
            awaited.push_back(o);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] idx);
            outcome_t o;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: status %0d entry_index %0d", st, idx);
                errors++;
                return;
            end
            o = awaited.pop_front();
            seen[o.status]++;
            if (st !== o.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", o.status, st);
                errors++;
            end
            if (idx !== o.entry_index)
            begin
                $error("entry_index mismatch: expected %0d, actual %0d", o.entry_index, idx);
                errors++;
            end
        endfunction

        function int unsigned checked();
            int unsigned total;
            total = 0;
            foreach (seen[i]) total += seen[i];
            return total;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int unsigned idle_phase;
    int unsigned stall_count;
    int unsigned sent;

    hstl_req_if req_ch();
    hstl_rsp_if rsp_ch();

    symbol_table_scoreboard sb = new();
    logic [NAME_W-1:0] pool [$];

    hashed_symbol_table_lookup_insert_core #(.SLOTS(SLOTS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned sender_pct();
        return (idle_phase == 1) ? 86 : (idle_phase == 3) ? 31 : 0;
    endfunction

    function automatic int unsigned receiver_pct();
        return (idle_phase == 2) ? 86 : (idle_phase == 3) ? 31 : 0;
    endfunction

    function automatic logic [NAME_W-1:0] random_name();
        return NAME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [NAME_W-1:0] name_homed_at(int unsigned target);
        logic [NAME_W-1:0] nm;
        nm = random_name();
        if (nm[NAME_W-2 -: CHAR_BITS-1] == '0) nm[NAME_W-CHAR_BITS] = 1'b1;
        nm[CHAR_BITS-1:0] = nm[CHAR_BITS-1:0] + CHAR_BITS'(target - sb.home_of(nm));
        return nm;
    endfunction

    function automatic logic [NAME_W-1:0] pick_known();
        logic [NAME_W-1:0] nm;
        nm = pool[$urandom_range(pool.size() - 1, 0)];
        if ($urandom_range(1, 0)) nm = nm ^ ({NAME_CHARS{8'h80}} & random_name());
        return nm;
    endfunction

    function automatic logic [NAME_W-1:0] fresh_name();
        logic [NAME_W-1:0] nm;
        int unsigned hot [6] = '{0, 1, 2, SLOTS - 3, SLOTS - 2, SLOTS - 1};
        if ($urandom_range(1, 0))
            nm = name_homed_at(hot[$urandom_range(5, 0)]);
        else
            nm = name_homed_at($urandom_range(SLOTS - 1, 0));
        return nm;
    endfunction

    task automatic send_item(input logic op, input logic [NAME_W-1:0] nm);
        if ($urandom_range(99, 0) < sender_pct())
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < sender_pct()) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.symbol_name <= nm;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_request(op, nm);
        if (op == OP_INSERT && !sb.is_vacant(nm)) pool.push_back(nm);
        sent++;
    endtask

    task automatic send_random();
        int unsigned r;
        logic op;
        logic [NAME_W-1:0] nm;
        r = $urandom_range(99, 0);
        if (r < 30 && pool.size() > 0)
            send_item(OP_LOOKUP, pick_known());
        else if (r < 42 && pool.size() > 0)
            send_item(OP_INSERT, pick_known());
        else if (r < 52)
            send_item(OP_INSERT, fresh_name());
        else if (r < 72)
            send_item(OP_LOOKUP, fresh_name());
        else if (r < 80)
        begin
            nm = random_name();
            nm[NAME_W-2 -: CHAR_BITS-1] = '0;
            send_item(logic'($urandom_range(1, 0)), nm);
        end
        else
        begin
            op = logic'($urandom_range(1, 0));
            send_item(op, random_name());
        end
    endtask

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.status, rsp_ch.entry_index);
            if (!held && sb.checked() >= HOLD_AT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= !($urandom_range(99, 0) < receiver_pct());
            end
        end
    end

    initial
    begin
        logic [NAME_W-1:0] wrap_a;
        logic [NAME_W-1:0] wrap_b;
        logic [NAME_W-1:0] wrap_c;
        idle_phase = 0;
        stall_count = 0;
        sent = 0;
        rst_n = 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_LOOKUP;
        req_ch.symbol_name <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        wrap_a = name_homed_at(SLOTS - 1);
        wrap_b = name_homed_at(SLOTS - 1);
        wrap_c = name_homed_at(SLOTS - 1);
        send_item(OP_LOOKUP, '0);
        send_item(OP_INSERT, '0);
        send_item(OP_LOOKUP, '0);
        send_item(OP_INSERT, {8'h80, {(NAME_W-8){1'b1}}});
        send_item(OP_INSERT, '1);
        send_item(OP_LOOKUP, {NAME_CHARS{8'h7f}});
        send_item(OP_INSERT, {NAME_CHARS{8'h7f}});
        send_item(OP_INSERT, wrap_a);
        send_item(OP_INSERT, wrap_b);
        send_item(OP_INSERT, wrap_c);
        send_item(OP_LOOKUP, wrap_c);
        send_item(OP_LOOKUP, name_homed_at(SLOTS - 1));
        send_item(OP_LOOKUP, wrap_b ^ {NAME_CHARS{8'h80}});
        send_item(OP_INSERT, wrap_b ^ {NAME_CHARS{8'h80}});
        send_item(OP_INSERT, {8'h01, {(NAME_W-8){1'b0}}});
        send_item(OP_LOOKUP, {8'h81, {(NAME_W-8){1'b0}}});

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_phase = (i / PHASE_ITEMS) % 4;
            send_random();
        end

        idle_phase = 3;
        while (sb.filled < SLOTS) send_item(OP_INSERT, name_homed_at($urandom_range(SLOTS - 1, 0)));
        send_item(OP_LOOKUP, pick_known());
        send_item(OP_INSERT, pick_known());
        send_item(OP_INSERT, fresh_name());
        send_item(OP_LOOKUP, fresh_name());
        send_item(OP_INSERT, '0);
        send_item(OP_LOOKUP, '1);
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests through all idling phases, ending on a full table.", sent);
        $display("Results: %0d found, %0d absent, %0d inserted, %0d full.",
                 sb.seen[hstl_pkg::ST_FOUND], sb.seen[hstl_pkg::ST_ABSENT],
                 sb.seen[hstl_pkg::ST_INSERTED], sb.seen[hstl_pkg::ST_FULL]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
src/hstl_pkg.sv
src/hstl_if.sv
src/hstl_ram.sv
src/hstl_fifo.sv
src/hstl_front.sv
src/hstl_back.sv
src/hashed_symbol_table_lookup_insert_core.sv
test/tb.sv
